// File: design/ffd_pkg.sv
// ffd_pkg: shared widths, register indexes, control struct and saturation helper
// for the fractional feedback delay. No dependencies.
package ffd_pkg;

    // default geometry
    localparam int RING_DEPTH_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 8;

    // field widths
    localparam int SMP_W  = 16;
    localparam int GAIN_W = 16;
    localparam int DLY_W  = 20;

    // datapath widths: accumulator, multiplier b operand, product
    localparam int AC_W = 22;
    localparam int MB_W = 17;
    localparam int P_W  = AC_W + MB_W;

    // feedback gain is Q1.15
    localparam int GAIN_FRAC = 15;

    // config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_GAIN  = 1'b0;
    localparam logic REG_DELAY = 1'b1;

    // control into the shared multiplier
    typedef struct packed {
        logic en;   // load a new product
        logic fb;   // round by the gain fraction instead of the delay fraction
    } t_mul_ctl;

    // clamp to the 16-bit sample range
    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [23:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/ffd_ram.sv
// ffd_ram: generic single-write, single-read ram with registered read data.
// Standalone, no package dependency.
module ffd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ffd_mul.sv
// ffd_mul: shared signed multiplier with registered product and round-half-up shift.
// Depends on ffd_pkg.
module ffd_mul
    import ffd_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_mul_ctl              i_ctl,
    input  logic signed [AC_W-1:0] i_a,
    input  logic signed [MB_W-1:0] i_b,
    output logic signed [P_W-1:0]  o_rnd
);

    localparam logic signed [P_W-1:0] HALF_FR = P_W'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [P_W-1:0] HALF_FB = P_W'(1) <<< (GAIN_FRAC - 1);

    logic signed [P_W-1:0] r_prod;
    logic                  r_fb;
    logic signed [P_W-1:0] sum;

    // product register
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= P_W'(i_a) * P_W'(i_b);
            r_fb   <= i_ctl.fb;
        end
    end

    // add half, then arithmetic shift (floor)
    always_comb begin
        sum   = r_prod + (r_fb ? HALF_FB : HALF_FR);
        o_rnd = r_fb ? (sum >>> GAIN_FRAC) : (sum >>> FRACTION_BITS);
    end

endmodule

// File: design/fractional_feedback_delay.sv
// fractional_feedback_delay: top level, sequencer, config registers, delay reduction.
// Depends on ffd_pkg, ffd_ram and ffd_mul.
//
// Usage: one Q1.15 sample per input transfer on i_valid/o_ready, one interpolated
// Q1.15 sample per output transfer on o_valid/i_ready. Config through the APB-style
// port: feedback_gain at byte address 0, delay_samples at byte address 4.
// Each item runs after its transfer through four ring reads over the single
// ram read port, then four dependent multiplies through one shared multiplier
// (three Horner steps and the feedback gain), then the ring write. A new sample
// is taken only once the sequencer is back in idle.
// A finished result waits in the output register while the next item is taken;
// if the receiver still holds the previous result when a new one finishes, the
// sequencer waits until that result transfers.
// After reset the ring is cleared over all RING_DEPTH entries (4096 by default),
// during which o_ready stays low. A write of delay_samples starts a reduction of
// the delay modulo the ring span, quotient then remainder, with o_ready held low.
module fractional_feedback_delay
    import ffd_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input sample channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [SMP_W-1:0]   i_sample_in,
    // output sample channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [SMP_W-1:0]   o_sample_out,
    // config port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int BW     = AW + FRACTION_BITS + 1;
    localparam int CW     = ((BW > DLY_W) ? BW : DLY_W) + 1;
    // reciprocal of the ring span: shift, constant width and product width
    localparam int RS     = DLY_W + BW;
    localparam int RW     = DLY_W + 3;
    localparam int DP_W   = RS + DLY_W;
    localparam logic [BW-1:0]    SPAN     = BW'(RING_DEPTH) << FRACTION_BITS;
    localparam logic [RW-1:0]    RECIP    = RW'(((DP_W'(1) << RS) + DP_W'(SPAN) - DP_W'(1))
                                                / DP_W'(SPAN));
    localparam logic [DLY_W-1:0] SPAN_LO  = DLY_W'(SPAN);
    localparam logic [AW-1:0]    LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [AW-1:0]    WRAP2    = AW'(RING_DEPTH - 2);

    // sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ADDR = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CAP  = 4'd4;
    localparam logic [3:0] S_M1   = 4'd5;
    localparam logic [3:0] S_A1   = 4'd6;
    localparam logic [3:0] S_M2   = 4'd7;
    localparam logic [3:0] S_A2   = 4'd8;
    localparam logic [3:0] S_M3   = 4'd9;
    localparam logic [3:0] S_A3   = 4'd10;
    localparam logic [3:0] S_SAT  = 4'd11;
    localparam logic [3:0] S_M4   = 4'd12;
    localparam logic [3:0] S_WR   = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    // config registers and delay reduction
    logic signed [GAIN_W-1:0] r_gain;
    logic [DLY_W-1:0]         r_dly;
    logic [DLY_W-1:0]         r_rem;
    logic [DLY_W-1:0]         r_quo;
    logic                     r_dcnt;
    logic                     r_dbusy;
    logic                     cfg_wr;
    logic                     dly_wr;
    logic [DP_W-1:0]          dly_prod;

    // sequencer and datapath registers
    logic [3:0]               r_state;
    logic [AW-1:0]            r_clr;
    logic [AW-1:0]            r_wp;
    logic [CW-1:0]            r_back;
    logic [AW-1:0]            r_i0;
    logic [FRACTION_BITS-1:0] r_x;
    logic [1:0]               r_k;
    logic                     r_rdv;
    logic signed [SMP_W-1:0]  r_y [4];
    logic signed [SMP_W-1:0]  r_sin;
    logic signed [AC_W-1:0]   r_c2;
    logic signed [AC_W-1:0]   r_c1;
    logic signed [AC_W-1:0]   r_acc;
    logic signed [SMP_W-1:0]  r_res;
    logic signed [SMP_W-1:0]  r_out;
    logic                     r_ovld;

    logic                     accept;
    logic                     out_load;
    logic [CW-1:0]            back_red;
    logic [AW-1:0]            i_m1;
    logic [AW-1:0]            i_p1;
    logic [AW-1:0]            i_p2;
    logic [AW-1:0]            rd_addr;
    logic [SMP_W-1:0]         rd_data;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic signed [SMP_W-1:0]  wr_val;
    logic signed [AC_W-1:0]   e_ym1;
    logic signed [AC_W-1:0]   e_y0;
    logic signed [AC_W-1:0]   e_y1;
    logic signed [AC_W-1:0]   e_y2;
    logic signed [AC_W-1:0]   c1;
    logic signed [AC_W-1:0]   c2;
    logic signed [AC_W-1:0]   c3;
    logic signed [AC_W-1:0]   half_acc;
    logic signed [23:0]       fb_sum;
    t_mul_ctl                 mul_ctl;
    logic signed [AC_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [P_W-1:0]    mul_rnd;

    // config write decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign dly_wr = cfg_wr && (paddr[2] == REG_DELAY);

    // config read mux
    always_comb begin
        case (paddr[2])
            REG_GAIN:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_gain};
            REG_DELAY: prdata = {{(PDATA_W-DLY_W){1'b0}}, r_dly};
            default:   prdata = '0;
        endcase
    end

    // quotient estimate by the span reciprocal, exact for every 20-bit delay
    assign dly_prod = DP_W'(r_dly) * DP_W'(RECIP);

    // config registers; delay reduced in two steps: quotient, then remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= '0;
            r_dly   <= '0;
            r_rem   <= '0;
            r_dbusy <= 1'b0;
            r_dcnt  <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[2] == REG_GAIN)) begin
                r_gain <= pwdata[GAIN_W-1:0];
            end
            if (dly_wr) begin
                r_dly   <= pwdata[DLY_W-1:0];
                r_dcnt  <= 1'b0;
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (!r_dcnt) begin
                    r_quo <= dly_prod[RS +: DLY_W];
                end else begin
                    r_rem   <= r_dly - r_quo * SPAN_LO;
                    r_dbusy <= 1'b0;
                end
                r_dcnt <= 1'b1;
            end
        end
    end

    // channel handshakes
    assign o_ready      = (r_state == S_IDLE) && !r_dbusy && !dly_wr;
    assign accept       = i_valid && o_ready;
    assign o_valid      = r_ovld;
    assign o_sample_out = r_out;
    assign out_load     = ((r_state == S_WR) || (r_state == S_OUT)) && (!r_ovld || i_ready);

    // look-back wrap and neighbour indices
    assign back_red = (r_back >= CW'(SPAN)) ? (r_back - CW'(SPAN)) : r_back;
    assign i_m1     = (r_i0 == '0) ? LAST_IDX : (r_i0 - 1'b1);
    assign i_p1     = (r_i0 == LAST_IDX) ? '0 : (r_i0 + 1'b1);
    assign i_p2     = (r_i0 >= WRAP2) ? (r_i0 - WRAP2) : (r_i0 + AW'(2));

    always_comb begin
        case (r_k)
            2'd0:    rd_addr = i_m1;
            2'd1:    rd_addr = r_i0;
            2'd2:    rd_addr = i_p1;
            2'd3:    rd_addr = i_p2;
            default: rd_addr = r_i0;
        endcase
    end

    // hermite coefficients at twice their value
    always_comb begin
        e_ym1 = AC_W'(r_y[0]);
        e_y0  = AC_W'(r_y[1]);
        e_y1  = AC_W'(r_y[2]);
        e_y2  = AC_W'(r_y[3]);
        c1    = e_y1 - e_ym1;
        c2    = (e_ym1 <<< 1) - ((e_y0 <<< 2) + e_y0) + (e_y1 <<< 2) - e_y2;
        c3    = (e_y2 - e_ym1) + ((e_y0 - e_y1) <<< 1) + (e_y0 - e_y1);
    end

    // shared multiplier operand select
    always_comb begin
        mul_ctl.en = (r_state == S_M1) || (r_state == S_M2) || (r_state == S_M3)
                     || (r_state == S_M4);
        mul_ctl.fb = (r_state == S_M4);
        case (r_state)
            S_M1:    mul_a = c3;
            S_M4:    mul_a = AC_W'(r_res);
            default: mul_a = r_acc;
        endcase
        if (r_state == S_M4) begin
            mul_b = MB_W'(r_gain);
        end else begin
            mul_b = MB_W'({1'b0, r_x});
        end
    end

    ffd_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .i_clk(i_clk),
        .i_ctl(mul_ctl),
        .i_a  (mul_a),
        .i_b  (mul_b),
        .o_rnd(mul_rnd)
    );

    // output rounding and feedback value
    assign half_acc = (r_acc + AC_W'(1)) >>> 1;
    assign fb_sum   = 24'(r_sin) + $signed(mul_rnd[23:0]);
    assign wr_val   = sat_smp(fb_sum);

    // ring write port: clearing pass or feedback write
    assign ram_we    = (r_state == S_CLR) || (r_state == S_WR);
    assign ram_waddr = (r_state == S_CLR) ? r_clr : r_wp;

    ffd_ram #(
        .WIDTH(SMP_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata((r_state == S_CLR) ? '0 : wr_val),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_wp    <= '0;
            r_k     <= '0;
            r_rdv   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_rdv <= (r_state == S_RD);
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_k     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_state <= S_CAP;
                    end
                end
                S_CAP:  r_state <= S_M1;
                S_M1:   r_state <= S_A1;
                S_A1:   r_state <= S_M2;
                S_M2:   r_state <= S_A2;
                S_A2:   r_state <= S_M3;
                S_M3:   r_state <= S_A3;
                S_A3:   r_state <= S_SAT;
                S_SAT:  r_state <= S_M4;
                S_M4:   r_state <= S_WR;
                S_WR: begin
                    r_wp    <= (r_wp == LAST_IDX) ? '0 : (r_wp + 1'b1);
                    r_state <= out_load ? S_IDLE : S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sin  <= i_sample_in;
            r_back <= CW'({r_wp, {FRACTION_BITS{1'b0}}}) + CW'(SPAN) - CW'(r_rem);
        end
        if (r_state == S_ADDR) begin
            r_i0 <= back_red[FRACTION_BITS +: AW];
            r_x  <= back_red[FRACTION_BITS-1:0];
        end
        // neighbours shift in oldest index first
        if (r_rdv) begin
            r_y[0] <= r_y[1];
            r_y[1] <= r_y[2];
            r_y[2] <= r_y[3];
            r_y[3] <= rd_data;
        end
        if (r_state == S_M1) begin
            r_c2 <= c2;
            r_c1 <= c1;
        end
        case (r_state)
            S_A1:    r_acc <= mul_rnd[AC_W-1:0] + r_c2;
            S_A2:    r_acc <= mul_rnd[AC_W-1:0] + r_c1;
            S_A3:    r_acc <= mul_rnd[AC_W-1:0] + (AC_W'(r_y[1]) <<< 1);
            default: r_acc <= r_acc;
        endcase
        if (r_state == S_SAT) begin
            r_res <= sat_smp(24'(half_acc));
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_ADDR))
        else $error("accepted sample did not start the sequence");

    a_delay_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dbusy |-> (CW'(r_rem) < CW'(SPAN)))
        else $error("reduced delay not below ring span");

    a_all_taps_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M1) |-> ($past(r_state) == S_CAP) && $past(r_rdv))
        else $error("interpolation started before last neighbour arrived");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WR) && r_ovld && !i_ready) |=> (r_state == S_OUT))
        else $error("new result while previous one untaken");

endmodule
